### hdl/lkt_pkg.sv
// shared types and constants for the lru key tracker
package lkt_pkg;

    localparam int ENTRIES  = 8;
    localparam int KEY_BITS = 16;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int CAP_W    = 4;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [CAP_W-1:0]    cap_t;

    // data handed from one cell to the next one toward the least-recent end
    typedef struct packed {
        key_t key;
        logic valid;
        logic seen;
    } link_t;

    // control broadcast to every cell
    typedef struct packed {
        logic load;
        logic hit;
        logic evict;
        key_t key;
    } ctrl_t;

endpackage

### hdl/lkt_cell.sv
// one position of the recency chain: holds a key and its valid bit
module lkt_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  lkt_pkg::ctrl_t ctrl,
    input  lkt_pkg::link_t prev,
    output lkt_pkg::link_t nxt,
    output logic          is_tail
);
    import lkt_pkg::*;

    key_t key_reg;
    key_t key_next;
    logic valid_reg;
    logic valid_next;
    logic match;
    logic take;

    assign match = valid_reg && (key_reg == ctrl.key);

    // hit: shift down to the matching cell; evict: every valid cell; insert: one past the end
    always_comb
    begin
        if (ctrl.hit)
        begin
            take = !prev.seen;
        end
        else if (ctrl.evict)
        begin
            take = valid_reg;
        end
        else
        begin
            take = prev.valid;
        end
    end

    assign key_next   = (ctrl.load && take) ? prev.key : key_reg;
    assign valid_next = valid_reg || (ctrl.load && !ctrl.hit && !ctrl.evict && prev.valid);

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign nxt.key   = key_reg;
    assign nxt.valid = valid_reg;
    assign nxt.seen  = prev.seen || match;

    // last valid cell; the top level qualifies it with the next cell's valid
    assign is_tail = valid_reg;

endmodule

### hdl/lru_key_tracker_unit.sv
// top level of the lru key tracker: cell row, occupancy count and result register
//
// keeps up to capacity keys ordered from most to least recently referenced.
// input channel s_*: one key per item. every item gives exactly one result item
// on m_*: hit flag, eviction flag, evicted key (zero when none) and occupancy
// after the reference. configuration channel cfg_*: writes the 4-bit capacity,
// always ready; zero acts as one, values above 8 act as 8. lowering capacity
// below occupancy keeps the stored keys, and later misses evict one for one.
// result: registered, and appears in the cycle after the item is accepted.
// throughput: one item per cycle while results are taken; the compare of all cells
// and the one-place shift of the row complete in the accepting cycle.
// reset: occupancy returns to zero, capacity to 3, the output register empties;
// no clearing pass is needed since each cell carries its own valid bit.
// stall: a held result blocks new items only while m_tready is low; the next
// item is taken in the same cycle the held result is taken.
module lru_key_tracker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] key
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [0] hit, [1] evicted, [17:2] evicted_key,
                                    // [21:18] occupancy, [23:22] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    import lkt_pkg::*;

    cap_t  cap_reg;
    cnt_t  count_reg;
    cnt_t  count_next;
    cnt_t  cap_eff;
    logic  out_valid_reg;
    logic  hit_reg;
    logic  evicted_reg;
    key_t  ev_key_reg;
    cnt_t  occ_reg;

    logic  accept;
    logic  full;
    logic  hit;
    key_t  ev_key;
    ctrl_t ctrl;
    link_t chain [ENTRIES+1];
    logic  tail  [ENTRIES];

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = cnt_t'(1);
        end
        else if (CAP_W'(cap_reg) > CAP_W'(ENTRIES))
        begin
            cap_eff = cnt_t'(ENTRIES);
        end
        else
        begin
            cap_eff = cnt_t'(cap_reg);
        end
    end

    assign full = count_reg >= cap_eff;
    assign hit  = chain[ENTRIES].seen;

    assign ctrl.load  = accept;
    assign ctrl.hit   = hit;
    assign ctrl.evict = !hit && full;
    assign ctrl.key   = s_tdata;

    // head of the chain: the new key enters cell 0
    assign chain[0].key   = s_tdata;
    assign chain[0].valid = 1'b1;
    assign chain[0].seen  = 1'b0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lkt_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (ctrl),
            .prev    (chain[i]),
            .nxt     (chain[i+1]),
            .is_tail (tail[i])
        );
    end

    // key of the last valid cell
    always_comb
    begin
        ev_key = '0;
        for (int i = 0; i < ENTRIES - 1; i++)
        begin
            if (tail[i] && !tail[i+1])
            begin
                ev_key = ev_key | chain[i+1].key;
            end
        end
        if (tail[ENTRIES-1])
        begin
            ev_key = ev_key | chain[ENTRIES].key;
        end
    end

    assign count_next = (accept && !hit && !full) ? count_reg + cnt_t'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= cap_t'(3);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_reg     <= hit;
            evicted_reg <= !hit && full;
            ev_key_reg  <= (!hit && full) ? ev_key : '0;
            occ_reg     <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, 4'(occ_reg), 16'(ev_key_reg), evicted_reg, hit_reg};

endmodule

### hdl/lkt_checker.sv
// port-level checks for the lru key tracker and their binding
module lkt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import lkt_pkg::*;

    // a held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("hit and eviction together");

    a_evkey: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[1] |-> m_tdata[17:2] == 16'd0)
        else $error("evicted key nonzero without eviction");

    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[21:18] != 4'd0) && (m_tdata[21:18] <= 4'(ENTRIES)))
        else $error("occupancy out of range");

endmodule

bind lru_key_tracker_unit lkt_checker u_lkt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### bench/tb_top.sv
// testbench for the lru key tracker: burst driver, stalling receiver, lru order predictor
module tb_top;
    import lkt_pkg::*;

    // result item as packed on m_tdata, lowest bit last
    typedef struct packed {
        logic [1:0] spare;
        cnt_t       occupancy;
        key_t       evicted_key;
        logic       evicted;
        logic       hit;
    } lru_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;        // [15:0] key
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;             // [0] hit, [1] evicted, [17:2] evicted_key,
                                      // [21:18] occupancy, [23:22] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    lru_key_tracker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    key_t        pending_keys[$];
    lru_result_t expected_results[$];

    // predictor state: keys ordered most recent first
    key_t trk_keys[ENTRIES];
    int   trk_count = 0;
    cap_t trk_capacity = cap_t'(3);

    int mismatches = 0;
    int n_refs = 0;
    int n_hits = 0;
    int n_evicts = 0;
    int n_cfg = 0;

    key_t key_pool[16];
    int   pool_n = 1;

    function automatic void move_toward_tail(int upto);
        for (int i = upto; i > 0; i--)
        begin
            if (i < ENTRIES)
                trk_keys[i] = trk_keys[i-1];
        end
    endfunction

    function automatic lru_result_t lru_reference(key_t k);
        lru_result_t r;
        int eff_cap;
        int found;
        int last;
        r = '0;
        eff_cap = int'(trk_capacity);
        found = -1;
        if (eff_cap == 0)
            eff_cap = 1;
        if (eff_cap > ENTRIES)
            eff_cap = ENTRIES;
        for (int i = 0; i < trk_count; i++)
        begin
            if (found < 0 && trk_keys[i] == k)
                found = i;
        end
        if (found >= 0)
        begin
            r.hit = 1'b1;
            move_toward_tail(found);
        end
        else if (trk_count >= eff_cap)
        begin
            // occupancy holds at or above capacity: one out, one in
            last = trk_count - 1;
            r.evicted = 1'b1;
            r.evicted_key = trk_keys[last];
            move_toward_tail(last);
        end
        else
        begin
            move_toward_tail(trk_count);
            trk_count++;
        end
        trk_keys[0] = k;
        r.occupancy = cnt_t'(trk_count);
        return r;
    endfunction

    // sender: bursts of random length, random gaps between them
    int burst_left = 8;
    int gap_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!(s_tvalid && !s_tready))
        begin
            if (s_tvalid)
                void'(pending_keys.pop_front());
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_keys.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_keys[0];
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern re-drawn from time to time at random from four modes
    int rx_cycle = 0;
    int rx_mode = 0;

    always @(posedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= rx_cycle[0];
            default: m_tready <= ((rx_cycle % 8) >= 5);
        endcase
    end

    // monitor: check results, predict accepted items, track capacity writes
    always @(posedge clk)
    begin
        lru_result_t got;
        lru_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = lru_result_t'(m_tdata);
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result item %h", m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit || got.evicted !== want.evicted ||
                        got.evicted_key !== want.evicted_key ||
                        got.occupancy !== want.occupancy || got.spare !== want.spare)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: hit %b/%b evicted %b/%b key %h/%h",
                                      " occ %0d/%0d (exp/act)"},
                                     want.hit, got.hit, want.evicted, got.evicted,
                                     want.evicted_key, got.evicted_key,
                                     want.occupancy, got.occupancy);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = lru_reference(s_tdata);
                expected_results = {expected_results, want};
                n_refs++;
                if (want.hit)
                    n_hits++;
                if (want.evicted)
                    n_evicts++;
            end
            if (cfg_valid && cfg_ready)
            begin
                trk_capacity = cfg_data;
                n_cfg++;
            end
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_keys.size() != 0 || s_tvalid || expected_results.size() != 0);
        // let the result register drain, plus margin
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(cap_t value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic key_t pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return key_pool[$urandom_range(0, pool_n - 1)];
        else if (r < 96)
            return key_t'($urandom);
        else if (r < 98)
            return '0;
        return '1;
    endfunction

    initial
    begin
        cap_t phase_cap;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset capacity of three: fill, hit on head and middle, evict when full
        pending_keys = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h5A5A,
                         16'hA5A5, 16'h5A5A, 16'h0001, 16'h8000};
        wait_idle();

        // zero acts as one while three keys are held: misses evict one for one
        write_capacity(cap_t'(0));
        pending_keys = '{16'h1111, 16'h1111, 16'h2222};
        wait_idle();

        // above the entry count saturates at eight
        write_capacity(cap_t'(15));
        pending_keys = '{16'h0100, 16'h0101, 16'h0102, 16'h0103, 16'h0104,
                         16'h0105, 16'h0106, 16'h0100, 16'h7FFF};
        wait_idle();

        // capacity lowered below occupancy
        write_capacity(cap_t'(1));
        pending_keys = '{16'h0102, 16'h4321, 16'h0105};
        wait_idle();

        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph)
                0: phase_cap = cap_t'(8);
                1: phase_cap = cap_t'(1);
                2: phase_cap = cap_t'(0);
                3: phase_cap = cap_t'(15);
                4: phase_cap = cap_t'(2);
                default: phase_cap = cap_t'($urandom_range(0, 15));
            endcase
            write_capacity(phase_cap);
            // pool slightly larger than capacity gives a mix of hits and evictions
            pool_n = ((phase_cap == 0) ? 1 : (phase_cap > ENTRIES ? ENTRIES : int'(phase_cap)))
                     + $urandom_range(0, 3);
            for (int i = 0; i < pool_n; i++)
                key_pool[i] = key_t'($urandom);
            for (int i = 0; i < 50; i++)
                pending_keys = {pending_keys, pick_key()};
            wait_idle();
        end

        repeat (4) @(posedge clk);
        if (expected_results.size() != 0)
            mismatches++;
        $display("run covered %0d references: %0d hits, %0d evictions", n_refs, n_hits, n_evicts);
        $display("%0d capacity writes, %0d mismatches", n_cfg, mismatches);
        if (mismatches == 0)
            $display("** lru_key_tracker_unit: PASSED **");
        else
            $display("** lru_key_tracker_unit: FAILED **");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout waiting for results");
        $display("** lru_key_tracker_unit: FAILED **");
        $finish;
    end

endmodule
